// File: design/scse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scse_pkg
// Shared constants of the sky coefficient spline evaluator.
// ----------------------------------------------------------------------------
package scse_pkg;
  localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
  localparam logic [20:0] ONE_Q20 = 21'd1048576;
  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_EVAL = 1'b1;
  localparam logic [0:0] REG_TURBIDITY = 1'b0;
  localparam logic [0:0] REG_ALBEDO = 1'b1;

  function automatic logic [3:0] binom5(input logic [2:0] k);
    case (k)
      3'd0, 3'd5: binom5 = 4'd1;
      3'd1, 3'd4: binom5 = 4'd5;
      default:    binom5 = 4'd10;
    endcase
  endfunction
endpackage

// File: design/scse_cbrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scse_cbrt
// Bit-serial cube root: each result bit is found by squaring the trial, then cubing and comparing.
// ----------------------------------------------------------------------------
module scse_cbrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [60:0] radicand,
  output logic        done,
  output logic [20:0] root
);
  import scse_pkg::*;

  logic [4:0]  bitpos;
  logic        busy;
  logic        phase;
  logic [41:0] sq;
  logic [20:0] trial;
  logic [62:0] cube;

  assign trial = root | (21'd1 << bitpos);
  assign cube  = 63'(sq) * 63'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        bitpos <= 5'd20;
        phase  <= 1'b0;
        root   <= '0;
      end else if (busy) begin
        if (!phase) begin
          sq    <= 42'(trial) * 42'(trial);
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          if (cube <= 63'(radicand)) root <= trial;
          if (bitpos == 5'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bitpos <= bitpos - 5'd1;
          end
        end
      end
    end
  end
endmodule

// File: design/sky_coefficient_spline_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sky_coefficient_spline_eval_top
// Sky model coefficient evaluator over a loaded table store.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_stall. opcode 0 writes one table word
// (no result). opcode 1 evaluates a coefficient: the angle is scaled, a
// bit-serial cube root gives the elevation, the Bernstein weights are built
// with one shared 34x34 signed multiplier, then 24 table words are read
// from the single-port store, each one read and then multiplied/accumulated
// through the same multiplier, then the bilinear blend through it again.
// in_stall is high while busy.
// The result sits in an output register on out_valid until taken; the block
// does not accept the next item until it is taken.
// Reset clears control state and sets turbidity 4.0, albedo 0.1. The table
// store is not cleared; every entry must be written before it is read.
// Configuration: APB, turbidity at 0x0, ground_albedo at 0x4.
// ----------------------------------------------------------------------------
module sky_coefficient_spline_eval_top #(
  parameter int PARAMS_PER_SET   = 9,
  parameter int TURBIDITY_LEVELS = 10,
  parameter int WORD_BITS        = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic [11:0]        load_address,
  input  logic signed [31:0] load_word,
  input  logic [1:0]         channel,
  input  logic [3:0]         param_index,
  input  logic [15:0]        sun_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] coefficient,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scse_pkg::*;

  localparam int EB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int SET_POINTS = 6 * TURBIDITY_LEVELS;
  localparam int CHAN_PARAM = PARAMS_PER_SET * SET_POINTS * 2;
  localparam int CHAN_RAD = SET_POINTS * 2;
  localparam int RAD_BASE = 3 * CHAN_PARAM;
  localparam int DEPTH = 3 * (CHAN_PARAM + CHAN_RAD);
  localparam int AW = $clog2(DEPTH + 1) < 13 ? 13 : $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCALE = 4'd1, S_CBRT = 4'd2,
    S_POW = 4'd3, S_WGT = 4'd4, S_RD = 4'd5, S_MAC = 4'd6, S_SPL = 4'd7,
    S_BLW = 4'd8, S_BLM = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11, S_LOAD = 4'd12;

  // configuration
  logic [15:0] turbidity;
  logic [16:0] ground_albedo;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      turbidity     <= 16'd16384;
      ground_albedo <= 17'd6554;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TURBIDITY && paddr[1:0] == 2'b00)
        turbidity <= pwdata[15:0];
      else if (paddr[2] == REG_ALBEDO && paddr[1:0] == 2'b00)
        ground_albedo <= pwdata[16:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {16'd0, turbidity};
    else if (paddr == 3'd4) prdata = {15'd0, ground_albedo};
  end

  // table store
  logic signed [EB-1:0] mem [DEPTH];
  logic signed [EB-1:0] rdata;
  logic [AW-1:0] raddr;

  // shared multiplier: signed 34x34 operands kept within 32x32 magnitude use
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  assign mp = ma * mb;

  logic [3:0]  state;
  logic [0:0]  op_r;
  logic [11:0] la_r;
  logic signed [31:0] lw_r;
  logic [15:0] ang_r;
  logic        zero_r;
  logic [AW-1:0] base, stride;
  logic [20:0] e, u;
  logic [20:0] ep [6];
  logic [20:0] up [6];
  logic [24:0] w [6];
  logic [2:0]  k;
  logic [1:0]  sp;
  logic        ph;
  logic signed [63:0] acc;
  logic signed [63:0] s [4];
  logic signed [95:0] bacc;
  logic [29:0] bw [4];
  logic [4:0]  t0, t1;
  logic [12:0] f;
  logic [16:0] a;
  logic        cb_start, cb_done;
  logic [20:0] cb_root;
  logic [60:0] x_r;
  logic signed [31:0] res;

  scse_cbrt u_cbrt (
    .clk(clk), .rst(rst), .start(cb_start), .radicand(x_r),
    .done(cb_done), .root(cb_root)
  );

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign coefficient = res;

  function automatic logic signed [63:0] rsh(input logic signed [95:0] v,
                                             input int n);
    logic [95:0] mag;
    mag = v[95] ? 96'(-v) : 96'(v);
    mag = (mag + (96'd1 << (n - 1))) >> n;
    rsh = v[95] ? -64'(mag) : 64'(mag);
  endfunction

  // turbidity decode
  always_comb begin
    logic [3:0] ti;
    logic [16:0] t0s;
    ti = turbidity[15:12];
    if (ti < 4'd1) t0 = 5'd1;
    else if (5'(ti) > 5'(TURBIDITY_LEVELS)) t0 = 5'(TURBIDITY_LEVELS);
    else t0 = 5'(ti);
    t1 = (t0 + 5'd1 > 5'(TURBIDITY_LEVELS)) ? 5'(TURBIDITY_LEVELS) : t0 + 5'd1;
    t0s = 17'(t0) << 12;
    if (17'(turbidity) <= t0s) f = '0;
    else if (17'(turbidity) - t0s > 17'd4096) f = 13'd4096;
    else f = 13'(17'(turbidity) - t0s);
    a = (ground_albedo > 17'd65536) ? 17'd65536 : ground_albedo;
  end

  // word address of spline sp, point k
  always_comb begin
    logic [AW-1:0] tl;
    tl = (sp[1] ? AW'(t1) : AW'(t0)) - AW'(1);
    raddr = base + stride * AW'(6) * tl + (sp[0] ? stride * AW'(SET_POINTS) : '0)
          + stride * AW'(k);
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && op_r == OP_LOAD && 32'(la_r) < 32'(DEPTH))
      mem[la_r[AW-2:0]] <= lw_r[EB-1:0];
    rdata <= mem[raddr[AW-2:0]];
  end

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      S_SCALE: begin ma = 34'(ang_r); mb = 34'(TWO_OVER_PI_Q30); end
      S_POW:   begin
        ma = ph ? 34'(up[k-1]) : 34'(ep[k-1]);
        mb = ph ? 34'(u) : 34'(e);
      end
      S_WGT:   begin ma = 34'(up[3'd5-k]); mb = 34'(ep[k]); end
      S_MAC:   begin ma = 34'(w[k]); mb = 34'(rdata); end
      S_BLW:   begin
        ma = k[0] ? 34'(a) : 34'(17'd65536 - a);
        mb = k[1] ? 34'(f) : 34'(13'd4096 - f);
      end
      // spline values stay within 33 bits signed
      S_BLM:   begin ma = 34'(s[k[1:0]]); mb = 34'(bw[k[1:0]]); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cb_start <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op_r <= opcode; la_r <= load_address; lw_r <= load_word;
          ang_r <= sun_angle;
          zero_r <= (channel > 2'd2) || (32'(param_index) > 32'(PARAMS_PER_SET));
          if (32'(param_index) < 32'(PARAMS_PER_SET)) begin
            base <= AW'(channel) * AW'(CHAN_PARAM) + AW'(param_index);
            stride <= AW'(PARAMS_PER_SET);
          end else begin
            base <= AW'(RAD_BASE) + AW'(channel) * AW'(CHAN_RAD);
            stride <= AW'(1);
          end
          state <= (opcode == OP_EVAL) ? S_SCALE : S_LOAD;
        end
        S_LOAD: state <= S_IDLE;
        S_SCALE: begin
          if (zero_r) begin
            res <= '0; state <= S_OUT;
          end else begin
            logic [31:0] sc;
            sc = 32'((mp[45:0] + 46'd8192) >> 14);
            x_r <= (sc >= 32'h4000_0000) ? '0 : 61'(32'h4000_0000 - sc) << 30;
            cb_start <= 1'b1;
            state <= S_CBRT;
          end
        end
        S_CBRT: begin
          cb_start <= 1'b0;
          if (cb_done) begin
            e <= cb_root; u <= ONE_Q20 - cb_root;
            ep[0] <= ONE_Q20; up[0] <= ONE_Q20;
            k <= 3'd1; ph <= 1'b0; state <= S_POW;
          end
        end
        S_POW: begin
          if (ph) up[k] <= 21'((mp[41:0] + 42'd524288) >> 20);
          else    ep[k] <= 21'((mp[41:0] + 42'd524288) >> 20);
          ph <= !ph;
          if (ph) begin
            if (k == 3'd5) begin k <= 3'd0; state <= S_WGT; end
            else k <= k + 3'd1;
          end
        end
        S_WGT: begin
          w[k] <= 25'(21'((mp[41:0] + 42'd524288) >> 20)) * 25'(binom5(k));
          if (k == 3'd5) begin
            k <= 3'd0; sp <= 2'd0; acc <= '0; state <= S_RD;
          end else k <= k + 3'd1;
        end
        S_RD: state <= S_MAC;
        S_MAC: begin
          acc <= acc + 64'(mp);
          if (k == 3'd5) state <= S_SPL;
          else begin k <= k + 3'd1; state <= S_RD; end
        end
        S_SPL: begin
          s[sp] <= rsh(96'(acc), 20);
          acc <= '0; k <= 3'd0;
          if (sp == 2'd3) begin
            bacc <= '0; state <= S_BLW;
          end else begin
            sp <= sp + 2'd1; state <= S_RD;
          end
        end
        S_BLW: begin
          // order: k0 = (1-a)(1-f) s00, k1 = a(1-f) s10, k2 = (1-a)f s01, k3 = a f s11
          bw[k[1:0]] <= 30'(mp);
          if (k == 3'd3) begin k <= 3'd0; state <= S_BLM; end
          else k <= k + 3'd1;
        end
        S_BLM: begin
          bacc <= bacc + 96'(mp);
          if (k == 3'd3) state <= S_FIN;
          else k <= k + 3'd1;
        end
        S_FIN: begin
          logic signed [63:0] r;
          r = rsh(bacc, 28);
          if (r > 64'((64'sd1 <<< (EB - 1)) - 1)) r = (64'sd1 <<< (EB - 1)) - 1;
          if (r < -(64'sd1 <<< (EB - 1))) r = -(64'sd1 <<< (EB - 1));
          res <= r[31:0];
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/sky_coefficient_spline_eval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sky_coefficient_spline_eval_checker
// Watches the item, result and APB channels, predicts each coefficient and
// compares it with the block's output in transfer order.
// ----------------------------------------------------------------------------
module sky_coefficient_spline_eval_checker
  import scse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic [11:0]        load_address,
  input  logic signed [31:0] load_word,
  input  logic [1:0]         channel,
  input  logic [3:0]         param_index,
  input  logic [15:0]        sun_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] coefficient,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count,
  output int                 load_count
);
  localparam int SETS         = 9;
  localparam int LEVELS       = 10;
  localparam int SET_POINTS   = 6 * LEVELS;
  localparam int CHAN_PARAMS  = SETS * SET_POINTS * 2;
  localparam int CHAN_RAD     = SET_POINTS * 2;
  localparam int RAD_BASE     = 3 * CHAN_PARAMS;
  localparam int DEPTH        = 3 * (CHAN_PARAMS + CHAN_RAD);

  logic signed [31:0] table_words [DEPTH];
  logic [15:0]        turb_q12;
  logic [16:0]        albedo_q16;
  logic signed [31:0] coeff_expected_q [$];

  function automatic longint round_half_away(longint v, int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic bit [63:0] q20_mul(bit [63:0] a, bit [63:0] b);
    return (a * b + 64'd524288) >> 20;
  endfunction

  function automatic longint spline_at(int base, int stride, bit [63:0] w [6]);
    longint acc;
    acc = 0;
    for (int k = 0; k < 6; k++)
      acc += longint'(w[k]) * longint'(table_words[base + k * stride]);
    return round_half_away(acc, 20);
  endfunction

  function automatic logic signed [31:0] predict_coefficient(
    logic [1:0] ch, logic [3:0] pi_idx, logic [15:0] ang);
    int base, stride;
    bit [63:0] scaled, x, e, u, t, ti, t0, t1, frac, alb, wa0, wt0;
    bit [63:0] ep [6];
    bit [63:0] up [6];
    bit [63:0] w [6];
    longint s00, s10, s01, s11, acc, r;
    if (ch > 2 || pi_idx > SETS) return '0;
    if (pi_idx < SETS) begin
      base = ch * CHAN_PARAMS + pi_idx;
      stride = SETS;
    end else begin
      base = RAD_BASE + ch * CHAN_RAD;
      stride = 1;
    end
    scaled = (64'(ang) * 64'(TWO_OVER_PI_Q30) + 64'd8192) >> 14;
    x = (scaled >= 64'd1 << 30) ? 64'd0 : (64'd1 << 30) - scaled;
    // bit-serial cube root of x in Q60 gives elevation in Q20
    e = 0;
    for (int b = 20; b >= 0; b--) begin
      t = e | (64'd1 << b);
      if (t * t * t <= (x << 30)) e = t;
    end
    u = 64'(ONE_Q20) - e;
    ep[0] = 64'(ONE_Q20);
    up[0] = 64'(ONE_Q20);
    for (int k = 1; k < 6; k++) begin
      ep[k] = q20_mul(ep[k - 1], e);
      up[k] = q20_mul(up[k - 1], u);
    end
    for (int k = 0; k < 6; k++)
      w[k] = 64'(binom5(3'(k))) * q20_mul(up[5 - k], ep[k]);
    ti = 64'(turb_q12) >> 12;
    t0 = (ti < 1) ? 64'd1 : (ti > LEVELS ? 64'(LEVELS) : ti);
    t1 = (t0 + 1 > LEVELS) ? 64'(LEVELS) : t0 + 1;
    if (64'(turb_q12) <= (t0 << 12)) frac = 0;
    else frac = (64'(turb_q12) - (t0 << 12) > 4096) ? 64'd4096 : 64'(turb_q12) - (t0 << 12);
    alb = (albedo_q16 > 17'd65536) ? 64'd65536 : 64'(albedo_q16);
    s00 = spline_at(base + stride * 6 * int'(t0 - 1), stride, w);
    s10 = spline_at(base + stride * SET_POINTS + stride * 6 * int'(t0 - 1), stride, w);
    s01 = spline_at(base + stride * 6 * int'(t1 - 1), stride, w);
    s11 = spline_at(base + stride * SET_POINTS + stride * 6 * int'(t1 - 1), stride, w);
    wa0 = 65536 - alb;
    wt0 = 4096 - frac;
    acc = s00 * longint'(wa0 * wt0) + s10 * longint'(alb * wt0)
        + s01 * longint'(wa0 * frac) + s11 * longint'(alb * frac);
    r = round_half_away(acc, 28);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  assign pending = coeff_expected_q.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      turb_q12   <= 16'd16384;
      albedo_q16 <= 17'd6554;
      coeff_expected_q.delete();
      fail_count <= 0;
      checked_count <= 0;
      load_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TURBIDITY) turb_q12 <= pwdata[15:0];
        else albedo_q16 <= pwdata[16:0];
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          if (load_address < DEPTH) table_words[load_address] = load_word;
          load_count <= load_count + 1;
        end else begin
          coeff_expected_q.push_back(predict_coefficient(channel, param_index, sun_angle));
        end
      end
      if (out_valid && !out_stall) begin
        if (coeff_expected_q.size() == 0) begin
          $error("unexpected coefficient transfer: %0d", coefficient);
          fail_count <= fail_count + 1;
        end else begin
          want = coeff_expected_q.pop_front();
          checked_count <= checked_count + 1;
          if (coefficient !== want) begin
            $error("coefficient mismatch: expected %0d, actual %0d", want, coefficient);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sky_coefficient_spline_eval_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sky_coefficient_spline_eval_top_tb
// Fills the coefficient store, then runs directed and random load/evaluate
// traffic over several turbidity/albedo settings with random idling on both
// channels; the checker predicts and compares every coefficient.
// ----------------------------------------------------------------------------
module sky_coefficient_spline_eval_top_tb;
  import scse_pkg::*;

  localparam int DEPTH       = 3600;
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [0:0]         opcode = OP_LOAD;
  logic [11:0]        load_address = '0;
  logic signed [31:0] load_word = '0;
  logic [1:0]         channel = '0;
  logic [3:0]         param_index = '0;
  logic [15:0]        sun_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] coefficient;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int  fail_count, pending, checked_count, load_count;
  int  cycle_count = 0;
  // calm stretches: no gaps on the item side, no stalls on the result side
  bit  calm = 1'b0;
  int  stall_left = 0;

  always #1 clk = ~clk;

  sky_coefficient_spline_eval_top uut (.*);

  sky_coefficient_spline_eval_checker chk (.*);

  // result side back-pressure: bursts of stall, mostly short, now and then long
  always @(negedge clk) begin
    logic hold;
    hold = 1'b0;
    if (!rst && !calm) begin
      if (stall_left > 0) begin
        stall_left--;
        hold = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(3);
        hold = 1'b1;
      end
    end
    out_stall <= hold;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(logic [0:0] op, logic [11:0] addr, logic signed [31:0] word,
                           logic [1:0] ch, logic [3:0] pidx, logic [15:0] ang);
    @(negedge clk);
    opcode       <= op;
    load_address <= addr;
    load_word    <= word;
    channel      <= ch;
    param_index  <= pidx;
    sun_angle    <= ang;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic item_gap();
    int n;
    if (calm) return;
    case ($urandom_range(9))
      0, 1, 2:  n = $urandom_range(3, 1);
      3:        n = $urandom_range(150, 15);
      default:  n = 0;
    endcase
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic load_word_at(logic [11:0] addr, logic signed [31:0] word);
    send_item(OP_LOAD, addr, word, '0, '0, '0);
  endtask

  task automatic evaluate(logic [1:0] ch, logic [3:0] pidx, logic [15:0] ang);
    send_item(OP_EVAL, 12'($urandom), 32'($urandom), ch, pidx, ang);
  endtask

  // wait for the block to drain before touching its registers
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic apb_write(logic [0:0] reg_sel, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'(25736 + $urandom_range(2) - 1);  // right at pi/2
      2:       return 16'($urandom_range(65535, 51473));
      3, 4, 5: return 16'($urandom_range(51472));
      default: return 16'($urandom_range(25736));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($signed($urandom_range(8388608)) - 4194304);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    logic [1:0] ch;
    logic [3:0] pidx;
    if ($urandom_range(9) < 3) begin
      // mostly in-range writes, some past the end of the store
      if ($urandom_range(9) == 0) load_word_at(12'($urandom_range(4095, DEPTH)), pick_word());
      else load_word_at(12'($urandom_range(DEPTH - 1)), pick_word());
    end else begin
      ch   = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      pidx = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      evaluate(ch, pidx, pick_angle());
    end
    item_gap();
  endtask

  initial begin
    logic [31:0] turb_set [9];
    logic [31:0] albedo_set [9];
    turb_set   = '{16384, 0, 65535, 4096, 40960, 40961, 0, 0, 0};
    albedo_set = '{6554, 0, 65536, 131071, 32768, 1, 0, 0, 0};
    for (int i = 6; i < 9; i++) begin
      turb_set[i]   = $urandom_range(65535);
      albedo_set[i] = $urandom_range(65536);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every store entry is written before any evaluation can read it
    calm = 1'b1;
    for (int a = 0; a < DEPTH; a++) load_word_at(12'(a), pick_word());
    calm = 1'b0;

    // directed: angle extremes, table kinds, out-of-range selectors
    evaluate(2'd0, 4'd0, 16'd0);
    evaluate(2'd1, 4'd8, 16'd25736);
    evaluate(2'd2, 4'd9, 16'd51472);
    evaluate(2'd0, 4'd9, 16'd65535);
    evaluate(2'd1, 4'd4, 16'd12868);
    evaluate(2'd3, 4'd0, 16'd100);
    evaluate(2'd0, 4'd10, 16'd100);
    evaluate(2'd2, 4'd15, 16'd100);
    load_word_at(12'd4095, 32'h7FFF_FFFF);
    load_word_at(12'd3600, 32'h8000_0000);
    // saturate: red radiance table all maximum, green all minimum
    calm = 1'b1;
    for (int k = 0; k < 120; k++) load_word_at(12'(3240 + k), 32'h7FFF_FFFF);
    for (int k = 0; k < 120; k++) load_word_at(12'(3360 + k), 32'h8000_0000);
    calm = 1'b0;
    evaluate(2'd0, 4'd9, 16'd0);
    evaluate(2'd0, 4'd9, 16'd20000);
    evaluate(2'd1, 4'd9, 16'd0);
    evaluate(2'd1, 4'd9, 16'd30000);

    // random traffic across register settings, reset values first
    for (int p = 0; p < 9; p++) begin
      settle();
      apb_write(REG_TURBIDITY, turb_set[p]);
      apb_write(REG_ALBEDO, albedo_set[p]);
      calm = (p == 4);
      for (int n = 0; n < 150; n++) random_item();
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d coefficient results and %0d table writes over 9 register settings",
             checked_count, load_count);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: files.f
design/scse_pkg.sv
design/scse_cbrt.sv
design/sky_coefficient_spline_eval_top.sv
tb/sky_coefficient_spline_eval_checker.sv
tb/sky_coefficient_spline_eval_top_tb.sv
